/* rtl/core/qau_pkg.sv */
// Shared types, constants and saturating fixed-point helpers for the quaternion unit.
package qau_pkg;

  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;

  typedef logic signed [DATA_W-1:0] comp_t;
  typedef logic [1:0] op_t;

  typedef struct packed {
    comp_t w;
    comp_t x;
    comp_t y;
    comp_t z;
  } quat_t;

  localparam op_t OP_MUL = 2'd0;
  localparam op_t OP_ROT = 2'd1;
  localparam op_t OP_INV = 2'd2;

  localparam comp_t COMP_MAX  = 32'sh7FFF_FFFF;
  localparam comp_t COMP_MIN  = 32'sh8000_0000;
  localparam comp_t COMP_ZERO = 32'sh0000_0000;

  // Register stages of each datapath, counted from the accepting edge.
  localparam int MUL_STAGES = 5;
  localparam int ROT_STAGES = 7;
  localparam int DIV_BITS   = DATA_W + FRAC_W;
  localparam int DIV_STAGES = DIV_BITS + 2;
  localparam int NORM_STAGES = 5;
  localparam int INV_STAGES = NORM_STAGES + DIV_STAGES;

  function automatic comp_t sat33(input logic signed [DATA_W:0] v);
    comp_t res;
    if (v[DATA_W] != v[DATA_W-1]) begin
      res = v[DATA_W] ? COMP_MIN : COMP_MAX;
    end else begin
      res = v[DATA_W-1:0];
    end
    return res;
  endfunction

  function automatic comp_t sat_add(input comp_t a, input comp_t b);
    logic signed [DATA_W:0] s;
    s = (DATA_W+1)'(a) + (DATA_W+1)'(b);
    return sat33(s);
  endfunction

  function automatic comp_t sat_sub(input comp_t a, input comp_t b);
    logic signed [DATA_W:0] s;
    s = (DATA_W+1)'(a) - (DATA_W+1)'(b);
    return sat33(s);
  endfunction

  // Floor shift of an exact product, then clamp to 32 bits.
  function automatic comp_t sat_shift(input logic signed [2*DATA_W-1:0] p,
                                      input int unsigned sh);
    logic signed [2*DATA_W-1:0] s;
    comp_t res;
    s = p >>> sh;
    if (s[2*DATA_W-1:DATA_W-1] == '0 || s[2*DATA_W-1:DATA_W-1] == '1) begin
      res = s[DATA_W-1:0];
    end else begin
      res = s[2*DATA_W-1] ? COMP_MIN : COMP_MAX;
    end
    return res;
  endfunction

endpackage

/* rtl/core/qau_mul.sv */
// Hamilton product datapath: product stage, scale stage, three saturating add stages.
module qau_mul (
  input  logic           clk,
  input  logic           en,
  input  qau_pkg::quat_t a,
  input  qau_pkg::quat_t b,
  output qau_pkg::quat_t r
);

  qau_pkg::comp_t opa [16];
  qau_pkg::comp_t opb [16];

  logic signed [2*qau_pkg::DATA_W-1:0] p_r [16];
  qau_pkg::comp_t t_r  [16];
  qau_pkg::comp_t s1_r [4];
  qau_pkg::comp_t t2_r [4];
  qau_pkg::comp_t t3_r [4];
  qau_pkg::comp_t s2_r [4];
  qau_pkg::comp_t t3b_r[4];
  qau_pkg::comp_t r_r  [4];

  // Term order per lane: x, y, z, then w; the w lane subtracts every later term.
  always_comb begin
    opa[0]  = a.w; opb[0]  = b.x;
    opa[1]  = a.x; opb[1]  = b.w;
    opa[2]  = a.y; opb[2]  = b.z;
    opa[3]  = a.z; opb[3]  = b.y;
    opa[4]  = a.w; opb[4]  = b.y;
    opa[5]  = a.y; opb[5]  = b.w;
    opa[6]  = a.z; opb[6]  = b.x;
    opa[7]  = a.x; opb[7]  = b.z;
    opa[8]  = a.w; opb[8]  = b.z;
    opa[9]  = a.z; opb[9]  = b.w;
    opa[10] = a.x; opb[10] = b.y;
    opa[11] = a.y; opb[11] = b.x;
    opa[12] = a.w; opb[12] = b.w;
    opa[13] = a.x; opb[13] = b.x;
    opa[14] = a.y; opb[14] = b.y;
    opa[15] = a.z; opb[15] = b.z;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 16; i++) begin
        p_r[i] <= opa[i] * opb[i];
        t_r[i] <= qau_pkg::sat_shift(p_r[i], qau_pkg::FRAC_W);
      end
      for (int c = 0; c < 3; c++) begin
        s1_r[c] <= qau_pkg::sat_add(t_r[4*c], t_r[4*c+1]);
        s2_r[c] <= qau_pkg::sat_add(s1_r[c], t2_r[c]);
      end
      s1_r[3] <= qau_pkg::sat_sub(t_r[12], t_r[13]);
      s2_r[3] <= qau_pkg::sat_sub(s1_r[3], t2_r[3]);
      for (int c = 0; c < 4; c++) begin
        t2_r[c]  <= t_r[4*c+2];
        t3_r[c]  <= t_r[4*c+3];
        t3b_r[c] <= t3_r[c];
        r_r[c]   <= qau_pkg::sat_sub(s2_r[c], t3b_r[c]);
      end
    end
  end

  always_comb begin
    r.x = r_r[0];
    r.y = r_r[1];
    r.z = r_r[2];
    r.w = r_r[3];
  end

endmodule

/* rtl/core/qau_rot.sv */
// Vector rotation datapath: two cross products in series, scaling and final sums.
module qau_rot (
  input  logic           clk,
  input  logic           en,
  input  qau_pkg::quat_t a,
  input  qau_pkg::quat_t b,
  output qau_pkg::quat_t r
);

  localparam int PW = 2 * qau_pkg::DATA_W;

  qau_pkg::comp_t opa [6];
  qau_pkg::comp_t opb [6];
  qau_pkg::comp_t qa  [9];
  qau_pkg::comp_t qb  [9];
  qau_pkg::comp_t d   [3];

  logic signed [PW-1:0] p_r [6];
  logic signed [PW-1:0] q_r [9];
  qau_pkg::quat_t a1_r, a2_r, a3_r;
  qau_pkg::comp_t b1_r [3];
  qau_pkg::comp_t b2_r [3];
  qau_pkg::comp_t b3_r [3];
  qau_pkg::comp_t b4_r [3];
  qau_pkg::comp_t b5_r [3];
  qau_pkg::comp_t t_r  [6];
  qau_pkg::comp_t u_r  [3];
  qau_pkg::comp_t tv_r [6];
  qau_pkg::comp_t su_r [3];
  qau_pkg::comp_t sv_r [3];
  qau_pkg::comp_t w1_r [3];
  qau_pkg::comp_t r_r  [3];

  always_comb begin
    opa[0] = a.y; opb[0] = b.z;
    opa[1] = a.z; opb[1] = b.y;
    opa[2] = a.z; opb[2] = b.x;
    opa[3] = a.x; opb[3] = b.z;
    opa[4] = a.x; opb[4] = b.y;
    opa[5] = a.y; opb[5] = b.x;
    // second cross product, then the 2w scaling terms
    qa[0] = a3_r.y; qb[0] = u_r[2];
    qa[1] = a3_r.z; qb[1] = u_r[1];
    qa[2] = a3_r.z; qb[2] = u_r[0];
    qa[3] = a3_r.x; qb[3] = u_r[2];
    qa[4] = a3_r.x; qb[4] = u_r[1];
    qa[5] = a3_r.y; qb[5] = u_r[0];
    qa[6] = u_r[0]; qb[6] = a3_r.w;
    qa[7] = u_r[1]; qb[7] = a3_r.w;
    qa[8] = u_r[2]; qb[8] = a3_r.w;
    for (int k = 0; k < 3; k++) begin
      d[k] = qau_pkg::sat_sub(tv_r[2*k], tv_r[2*k+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r <= a;
      a2_r <= a1_r;
      a3_r <= a2_r;
      b1_r[0] <= b.x;
      b1_r[1] <= b.y;
      b1_r[2] <= b.z;
      for (int i = 0; i < 6; i++) begin
        p_r[i]  <= opa[i] * opb[i];
        t_r[i]  <= qau_pkg::sat_shift(p_r[i], qau_pkg::FRAC_W);
        tv_r[i] <= qau_pkg::sat_shift(q_r[i], qau_pkg::FRAC_W);
      end
      for (int i = 0; i < 9; i++) begin
        q_r[i] <= qa[i] * qb[i];
      end
      for (int k = 0; k < 3; k++) begin
        b2_r[k] <= b1_r[k];
        b3_r[k] <= b2_r[k];
        b4_r[k] <= b3_r[k];
        b5_r[k] <= b4_r[k];
        u_r[k]  <= qau_pkg::sat_sub(t_r[2*k], t_r[2*k+1]);
        su_r[k] <= qau_pkg::sat_shift(q_r[6+k], qau_pkg::FRAC_W - 1);
        sv_r[k] <= qau_pkg::sat_add(d[k], d[k]);
        w1_r[k] <= qau_pkg::sat_add(b5_r[k], su_r[k]);
        r_r[k]  <= qau_pkg::sat_add(w1_r[k], sv_r[k]);
      end
    end
  end

  always_comb begin
    r.w = qau_pkg::COMP_ZERO;
    r.x = r_r[0];
    r.y = r_r[1];
    r.z = r_r[2];
  end

endmodule

/* rtl/core/qau_div.sv */
// One quotient lane: pipelined restoring divider, one quotient bit per stage.
module qau_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [qau_pkg::DATA_W:0] num,
  input  logic [qau_pkg::DATA_W-2:0]    den,
  output qau_pkg::comp_t                q
);

  localparam int DW = qau_pkg::DATA_W;
  localparam int QW = qau_pkg::DIV_BITS;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [QW-1:0] nq;
    logic [DW-2:0] dvs;
    logic          neg;
  } div_st_t;

  div_st_t       st_r [QW+1];
  div_st_t       st_nxt [QW+1];
  logic [DW:0]   mag;
  logic [QW-1:0] qf;
  qau_pkg::comp_t q_nxt;
  qau_pkg::comp_t q_r;

  always_comb begin
    mag = num[DW] ? (DW+1)'(-num) : (DW+1)'(num);
    st_nxt[0].rem = '0;
    st_nxt[0].nq  = {mag[DW-1:0], {qau_pkg::FRAC_W{1'b0}}};
    st_nxt[0].dvs = den;
    st_nxt[0].neg = num[DW];
    for (int k = 1; k <= QW; k++) begin
      logic [DW-1:0] trial;
      trial = {st_r[k-1].rem[DW-2:0], st_r[k-1].nq[QW-1]};
      st_nxt[k] = st_r[k-1];
      if (trial >= {1'b0, st_r[k-1].dvs}) begin
        st_nxt[k].rem = trial - {1'b0, st_r[k-1].dvs};
        st_nxt[k].nq  = {st_r[k-1].nq[QW-2:0], 1'b1};
      end else begin
        st_nxt[k].rem = trial;
        st_nxt[k].nq  = {st_r[k-1].nq[QW-2:0], 1'b0};
      end
    end
  end

  // Apply sign and clamp the magnitude to the 32-bit range.
  always_comb begin
    qf = st_r[QW].nq;
    if (!st_r[QW].neg) begin
      q_nxt = (qf[QW-1:DW-1] != '0) ? qau_pkg::COMP_MAX : qf[DW-1:0];
    end else if (qf[QW-1:DW] != '0 || (qf[DW-1] && qf[DW-2:0] != '0)) begin
      q_nxt = qau_pkg::COMP_MIN;
    end else begin
      q_nxt = -qf[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= QW; k++) begin
        st_r[k] <= st_nxt[k];
      end
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

/* rtl/core/qau_inv.sv */
// Inverse datapath: squared norm over five stages, then four divider lanes.
module qau_inv (
  input  logic           clk,
  input  logic           en,
  input  qau_pkg::quat_t a,
  output qau_pkg::quat_t r,
  output logic           err
);

  localparam int DW = qau_pkg::DATA_W;
  localparam int DS = qau_pkg::DIV_STAGES;

  logic signed [2*DW-1:0] sq_r [4];
  qau_pkg::comp_t t_r [4];
  qau_pkg::comp_t t2_r, t3_r, t3b_r;
  qau_pkg::comp_t n1_r, n2_r, n_r;
  qau_pkg::quat_t c1_r, c2_r, c3_r, c4_r, c5_r;
  logic err_r [DS];
  logic signed [DW:0] num [4];
  qau_pkg::comp_t     lq  [4];

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r[0] <= a.w * a.w;
      sq_r[1] <= a.x * a.x;
      sq_r[2] <= a.y * a.y;
      sq_r[3] <= a.z * a.z;
      for (int i = 0; i < 4; i++) begin
        t_r[i] <= qau_pkg::sat_shift(sq_r[i], qau_pkg::FRAC_W);
      end
      c1_r  <= a;
      c2_r  <= c1_r;
      c3_r  <= c2_r;
      c4_r  <= c3_r;
      c5_r  <= c4_r;
      n1_r  <= qau_pkg::sat_add(t_r[0], t_r[1]);
      t2_r  <= t_r[2];
      t3_r  <= t_r[3];
      n2_r  <= qau_pkg::sat_add(n1_r, t2_r);
      t3b_r <= t3_r;
      n_r   <= qau_pkg::sat_add(n2_r, t3b_r);
      err_r[0] <= (n_r == qau_pkg::COMP_ZERO);
      for (int k = 1; k < DS; k++) begin
        err_r[k] <= err_r[k-1];
      end
    end
  end

  // Conjugate: negate the vector part exactly in 33 bits.
  always_comb begin
    num[0] = (DW+1)'(c5_r.w);
    num[1] = -((DW+1)'(c5_r.x));
    num[2] = -((DW+1)'(c5_r.y));
    num[3] = -((DW+1)'(c5_r.z));
  end

  for (genvar g = 0; g < 4; g++) begin : g_lane
    qau_div u_div (
      .clk (clk),
      .en  (en),
      .num (num[g]),
      .den (n_r[DW-2:0]),
      .q   (lq[g])
    );
  end

  always_comb begin
    err = err_r[DS-1];
    if (err) begin
      r = '0;
    end else begin
      r.w = lq[0];
      r.x = lq[1];
      r.y = lq[2];
      r.z = lq[3];
    end
  end

endmodule

/* rtl/core/quaternion_arithmetic_unit.sv */
// Path: an accepted word passes every datapath stage and the result register before
// it is shown on the out_ ports. Throughput: one word per cycle unless the output
// word is held; all stages advance together, so a stalled valid output word holds
// the whole pipeline, as deep as the norm stages plus the 50-stage divider lanes.
// Reset: synchronous rst_n clears all valid bits; data registers are not reset.
module quaternion_arithmetic_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_opcode,
  input  logic signed [31:0]    in_a_w,
  input  logic signed [31:0]    in_a_x,
  input  logic signed [31:0]    in_a_y,
  input  logic signed [31:0]    in_a_z,
  input  logic signed [31:0]    in_b_w,
  input  logic signed [31:0]    in_b_x,
  input  logic signed [31:0]    in_b_y,
  input  logic signed [31:0]    in_b_z,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [31:0]    out_r_w,
  output logic signed [31:0]    out_r_x,
  output logic signed [31:0]    out_r_y,
  output logic signed [31:0]    out_r_z,
  output logic                  out_zero_norm_error
);

  localparam int NS      = qau_pkg::INV_STAGES;
  localparam int MUL_PAD = qau_pkg::INV_STAGES - qau_pkg::MUL_STAGES;
  localparam int ROT_PAD = qau_pkg::INV_STAGES - qau_pkg::ROT_STAGES;

  logic en;
  qau_pkg::quat_t a, b;
  qau_pkg::quat_t mul_q, rot_q, inv_q;
  logic inv_err;

  logic          vld_r [NS];
  qau_pkg::op_t  op_r  [NS];
  qau_pkg::quat_t md_r [MUL_PAD];
  qau_pkg::quat_t rd_r [ROT_PAD];

  qau_pkg::quat_t res_nxt;
  logic           err_nxt;
  qau_pkg::quat_t res_r;
  logic           err_r;
  logic           out_valid_r;

  // Advance everything unless the output word is held.
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  always_comb begin
    a.w = in_a_w;
    a.x = in_a_x;
    a.y = in_a_y;
    a.z = in_a_z;
    b.w = in_b_w;
    b.x = in_b_x;
    b.y = in_b_y;
    b.z = in_b_z;
  end

  qau_mul u_mul (.clk(clk), .en(en), .a(a), .b(b), .r(mul_q));
  qau_rot u_rot (.clk(clk), .en(en), .a(a), .b(b), .r(rot_q));
  qau_inv u_inv (.clk(clk), .en(en), .a(a), .r(inv_q), .err(inv_err));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NS; k++) begin
        vld_r[k] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
      out_valid_r <= vld_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_r[0] <= in_opcode;
      for (int k = 1; k < NS; k++) begin
        op_r[k] <= op_r[k-1];
      end
      md_r[0] <= mul_q;
      for (int k = 1; k < MUL_PAD; k++) begin
        md_r[k] <= md_r[k-1];
      end
      rd_r[0] <= rot_q;
      for (int k = 1; k < ROT_PAD; k++) begin
        rd_r[k] <= rd_r[k-1];
      end
      res_r <= res_nxt;
      err_r <= err_nxt;
    end
  end

  always_comb begin
    res_nxt = '0;
    err_nxt = 1'b0;
    unique case (op_r[NS-1])
      qau_pkg::OP_MUL: res_nxt = md_r[MUL_PAD-1];
      qau_pkg::OP_ROT: res_nxt = rd_r[ROT_PAD-1];
      qau_pkg::OP_INV: begin
        res_nxt = inv_q;
        err_nxt = inv_err;
      end
      default: begin
        res_nxt = '0;
        err_nxt = 1'b0;
      end
    endcase
  end

  assign out_valid           = out_valid_r;
  assign out_r_w             = res_r.w;
  assign out_r_x             = res_r.x;
  assign out_r_y             = res_r.y;
  assign out_r_z             = res_r.z;
  assign out_zero_norm_error = err_r;

endmodule

/* rtl/core/qau_chk.sv */
// Port-level checker for the quaternion unit and its bind.
module qau_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_r_w,
  input logic signed [31:0] out_r_x,
  input logic signed [31:0] out_r_y,
  input logic signed [31:0] out_r_z,
  input logic               out_zero_norm_error
);

  // No word leaves right after reset.
  a_reset_empty: assert property (@(posedge clk) !$past(rst_n) |-> !out_valid)
    else $error("out_valid high right after reset");

  // The input side only stalls behind a held output word.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a held output word");

  // A zero-norm error carries an all-zero quaternion.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_norm_error) |->
      (out_r_w == 0 && out_r_x == 0 && out_r_y == 0 && out_r_z == 0))
    else $error("zero-norm error with nonzero result");

  // A held word keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_r_w) && $stable(out_r_x)
      && $stable(out_r_y) && $stable(out_r_z) && $stable(out_zero_norm_error)))
    else $error("stalled output word changed");

endmodule

bind quaternion_arithmetic_unit qau_chk u_qau_chk (.*);
